// ----- design/amd_pkg.sv -----
// Shared types and constants for the accelerometer magnitude and direction block.
package amd_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int SUM_W = 26;
  localparam int ROOT_W = 13;
  localparam int PSQ_W = 58;
  localparam int HROOT_W = 29;
  localparam int CX_W = 32;
  localparam int ANG_W = 33;
  localparam int AXES = 3;
  localparam logic [ANG_W-1:0] PI_Q30 = 33'd3373259426;
  localparam logic [ANG_W-1:0] PI_HALF_Q30 = 33'd1686629713;

  typedef struct packed {
    logic [15:0] x_word;
    logic [15:0] y_word;
    logic [15:0] z_word;
  } amd_in_t;

  typedef struct packed {
    logic [12:0] magnitude;
    logic [15:0] angle_x;
    logic [15:0] angle_y;
    logic [15:0] angle_z;
    logic        zero_vector;
  } amd_out_t;

  typedef struct packed {
    logic axis_zero;
    logic perp_zero;
    logic neg;
  } amd_axis_flags_t;

  function automatic logic [ANG_W-1:0] atan_q30(input int i);
    logic [ANG_W-1:0] t;
    unique case (i)
      0: t = 33'd843314857;
      1: t = 33'd497837829;
      2: t = 33'd263043837;
      3: t = 33'd133525159;
      4: t = 33'd67021687;
      5: t = 33'd33543516;
      6: t = 33'd16775851;
      7: t = 33'd8388437;
      8: t = 33'd4194283;
      9: t = 33'd2097149;
      default: t = ANG_W'(64'd1 << (30 - i));
    endcase
    return t;
  endfunction

endpackage

// ----- design/amd_sqrt_pipe.sv -----
// Pipelined restoring square root, one result bit per stage, with side payload.
module amd_sqrt_pipe import amd_pkg::*; #(
  parameter int IN_W = 58,
  parameter int OUT_W = 29,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   radicand,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [OUT_W-1:0]  root,
  output logic [OUT_W:0]    remainder,
  output logic [SIDE_W-1:0] out_side
);

  localparam int PAD_W = 2 * OUT_W;

  logic [PAD_W-1:0]  rad_s [OUT_W+1];
  logic [OUT_W:0]    rem_s [OUT_W+1];
  logic [OUT_W-1:0]  root_s [OUT_W+1];
  logic [SIDE_W-1:0] side_s [OUT_W+1];
  logic              vld_s [OUT_W+1];

  assign rad_s[0] = PAD_W'(radicand);
  assign rem_s[0] = '0;
  assign root_s[0] = '0;
  assign side_s[0] = in_side;
  assign vld_s[0] = in_valid;

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic [OUT_W+1:0] trial;
    logic [OUT_W+1:0] cand;
    // The partial remainder entering a stage is at most twice the partial root,
    // so its top bit is always clear there.
    assign cand = {rem_s[k][OUT_W-1:0], rad_s[k][PAD_W-1 -: 2]};
    assign trial = cand - {root_s[k], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
      rad_s[k+1] <= rad_s[k] << 2;
      side_s[k+1] <= side_s[k];
      if (!trial[OUT_W+1]) begin
        rem_s[k+1] <= trial[OUT_W:0];
        root_s[k+1] <= {root_s[k][OUT_W-2:0], 1'b1};
      end else begin
        rem_s[k+1] <= cand[OUT_W:0];
        root_s[k+1] <= {root_s[k][OUT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld_s[OUT_W];
  assign root = root_s[OUT_W];
  assign remainder = rem_s[OUT_W];
  assign out_side = side_s[OUT_W];

endmodule

// ----- design/amd_cordic_pipe.sv -----
// Pipelined CORDIC vectoring unit, one rotation per stage, Q30 angle out.
module amd_cordic_pipe import amd_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [CX_W-1:0]   x_in,
  input  logic [CX_W-1:0]   y_in,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ANG_W-1:0]  angle,
  output logic [SIDE_W-1:0] out_side
);

  logic signed [CX_W+1:0]  xs [CORDIC_STEPS+1];
  logic signed [CX_W+1:0]  ys [CORDIC_STEPS+1];
  logic signed [ANG_W:0]   as_ [CORDIC_STEPS+1];
  logic [SIDE_W-1:0]       sd [CORDIC_STEPS+1];
  logic                    vl [CORDIC_STEPS+1];

  assign xs[0] = $signed({2'b00, x_in});
  assign ys[0] = $signed({2'b00, y_in});
  assign as_[0] = '0;
  assign sd[0] = in_side;
  assign vl[0] = in_valid;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CX_W+1:0] dx, dy;
    logic signed [ANG_W:0] t;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign t = $signed({1'b0, atan_q30(i)});
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else begin
        vl[i+1] <= vl[i];
      end
      sd[i+1] <= sd[i];
      if (!ys[i][CX_W+1]) begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        as_[i+1] <= as_[i] + t;
      end else begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        as_[i+1] <= as_[i] - t;
      end
    end
  end

  assign out_valid = vl[CORDIC_STEPS];
  assign angle = as_[CORDIC_STEPS][ANG_W] ? '0 : as_[CORDIC_STEPS][ANG_W-1:0];
  assign out_side = sd[CORDIC_STEPS];

  // Unused x path bits are consumed only through the rotations above.
  logic unused_x;
  assign unused_x = ^xs[CORDIC_STEPS];

endmodule

// ----- design/accel_magnitude_direction.sv -----
// Top level: squares, magnitude root, per-axis perpendicular roots and CORDIC angle pipes.
// Path from accepted start to done strobe: square register, sum register, root stages, CORDIC stages, output register.
// Throughput: one sample per cycle; busy is never raised, every stage is a register.
// Each rotation and each root bit is its own pipeline stage.
// Reset (rst, synchronous, active high) clears all valid bits; no result follows.
// The receiver cannot stall: done is high for exactly one cycle per result.
module accel_magnitude_direction import amd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 14
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  amd_in_t  sample,
  output logic     busy,
  output logic     done,
  output amd_out_t result
);

  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam int SIDE_W = AXES * 13 + 1 + AXES * 3;

  assign busy = 1'b0;

  // Stage 1: sign extend and square.
  logic signed [12:0] c1 [AXES];
  logic [SUM_W-1:0] sq1 [AXES];
  logic v1;
  logic [15:0] w [AXES];
  logic signed [SUM_W-1:0] wx [AXES];
  assign w[0] = sample.x_word;
  assign w[1] = sample.y_word;
  assign w[2] = sample.z_word;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      wx[a] = SUM_W'($signed(w[a][12:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    for (int a = 0; a < AXES; a++) begin
      c1[a] <= $signed(w[a][12:0]);
      sq1[a] <= wx[a] * wx[a];
    end
  end

  // Stage 2: sum and perpendicular squares.
  logic [SUM_W-1:0] sum2;
  logic [SUM_W-1:0] perp2 [AXES];
  logic [12:0] abs2 [AXES];
  amd_axis_flags_t fl2 [AXES];
  logic v2;
  logic [SUM_W-1:0] sum1;
  assign sum1 = sq1[0] + sq1[1] + sq1[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sum2 <= sum1;
    for (int a = 0; a < AXES; a++) begin
      perp2[a] <= sum1 - sq1[a];
      abs2[a] <= c1[a][12] ? 13'(-c1[a]) : 13'(c1[a]);
      fl2[a].axis_zero <= (c1[a] == '0);
      fl2[a].perp_zero <= (sum1 == sq1[a]);
      fl2[a].neg <= c1[a][12];
    end
  end

  // Roots: magnitude root and three perpendicular roots run in lockstep.
  logic [SIDE_W-1:0] side2, side3;
  logic [HROOT_W-1:0] h3 [AXES];
  logic [HROOT_W:0] rem_m;
  logic [HROOT_W-1:0] root_m;
  logic [12:0] abs3 [AXES];
  logic v3;
  logic [AXES-1:0] vh;

  // The magnitude root runs on the plain sum with the same stage count, so the
  // axis magnitudes and flags ride along with it.
  assign side2 = {abs2[0], abs2[1], abs2[2], (sum2 == '0), fl2[0], fl2[1], fl2[2]};

  amd_sqrt_pipe #(.IN_W(PSQ_W), .OUT_W(HROOT_W), .SIDE_W(SIDE_W)) u_mag (
    .clk(clk), .rst(rst), .in_valid(v2),
    .radicand(PSQ_W'(sum2)), .in_side(side2),
    .out_valid(v3), .root(root_m), .remainder(rem_m), .out_side(side3)
  );

  for (genvar a = 0; a < AXES; a++) begin : g_h
    logic [HROOT_W:0] rem_unused;
    logic side_unused;
    logic unused_h;
    amd_sqrt_pipe #(.IN_W(PSQ_W), .OUT_W(HROOT_W), .SIDE_W(1)) u_h (
      .clk(clk), .rst(rst), .in_valid(v2),
      .radicand({perp2[a], 32'd0}), .in_side(1'b0),
      .out_valid(vh[a]), .root(h3[a]), .remainder(rem_unused), .out_side(side_unused)
    );
    assign unused_h = ^{rem_unused, side_unused};
    assign abs3[a] = side3[SIDE_W-1-13*a -: 13];
  end

  logic [ROOT_W-1:0] mag3;
  assign mag3 = ROOT_W'(root_m) + ROOT_W'(rem_m > {1'b0, root_m} ? 1 : 0);

  // CORDIC side payload: magnitude, zero flag and axis flags.
  localparam int CS_W = ROOT_W + 1 + AXES * 3;
  logic [CS_W-1:0] cside_in;
  assign cside_in = {mag3, side3[AXES*3 +: 1], side3[AXES*3-1:0]};

  logic [ANG_W-1:0] ang4 [AXES];
  logic [CS_W-1:0] cside4;
  logic [AXES-1:0] v4;
  logic [CS_W-1:0] cs_unused [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_c
    amd_cordic_pipe #(.SIDE_W(CS_W)) u_c (
      .clk(clk), .rst(rst), .in_valid(v3),
      .x_in({3'b000, abs3[a], 16'd0}), .y_in(CX_W'(h3[a])),
      .in_side(cside_in), .out_valid(v4[a]), .angle(ang4[a]), .out_side(cs_unused[a])
    );
  end
  assign cside4 = cs_unused[0];

  function automatic logic [15:0] to_out(input logic [ANG_W-1:0] q);
    logic [ANG_W:0] r;
    r = ({1'b0, q} + (ANG_W+1)'(64'd1 << (SH - 1))) >> SH;
    return (r > (ANG_W+1)'(16'hFFFF)) ? 16'hFFFF : r[15:0];
  endfunction

  // Final stage: special cases, sign fold and rounding.
  logic [15:0] ang_o [AXES];
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      amd_axis_flags_t f;
      f = cside4[(AXES-1-a)*3 +: 3];
      priority if (f.axis_zero) ang_o[a] = to_out(PI_HALF_Q30);
      else if (f.perp_zero) ang_o[a] = f.neg ? to_out(PI_Q30) : 16'd0;
      else if (f.neg) ang_o[a] = to_out(PI_Q30 - ang4[a]);
      else ang_o[a] = to_out(ang4[a]);
    end
  end

  logic zero4;
  assign zero4 = cside4[AXES*3];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4[0];
    end
    result.magnitude <= zero4 ? '0 : cside4[CS_W-1 -: ROOT_W];
    result.angle_x <= zero4 ? '0 : ang_o[0];
    result.angle_y <= zero4 ? '0 : ang_o[1];
    result.angle_z <= zero4 ? '0 : ang_o[2];
    result.zero_vector <= zero4;
  end

  logic unused_v;
  assign unused_v = ^{vh, v4[2:1], cs_unused[1], cs_unused[2]};

  a_lockstep: assert property (@(posedge clk) disable iff (rst) v4[0] == v4[1] && v4[1] == v4[2])
    else $error("angle pipes out of lockstep");
  a_done_follows: assert property (@(posedge clk) disable iff (rst) v4[0] |=> done)
    else $error("done missing after pipe output");
  a_zero_mag: assert property (@(posedge clk) disable iff (rst)
    done && result.zero_vector |-> result.magnitude == '0)
    else $error("zero vector with nonzero magnitude");

endmodule
